>>> design/cbcc_pkg.sv
package cbcc_pkg;

    localparam int SIZE_BITS_DEFAULT = 32;

    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_SEMI = 8'h3B;

    typedef enum logic [3:0] {
        PH_SIZE     = 4'd0,
        PH_SIZE_CR  = 4'd1,
        PH_EXT      = 4'd2,
        PH_EXT_CR   = 4'd3,
        PH_DATA     = 4'd4,
        PH_DATA_CR  = 4'd5,
        PH_DATA_LF  = 4'd6,
        PH_TRAIL    = 4'd7,
        PH_TRAIL_CR = 4'd8,
        PH_DONE     = 4'd9,
        PH_BAD      = 4'd10
    } t_phase;

    typedef enum logic [1:0] {
        VERDICT_INCOMPLETE = 2'd0,
        VERDICT_COMPLETE   = 2'd1,
        VERDICT_MALFORMED  = 2'd2
    } t_verdict;

    // msb flags a hex digit, low nibble is its value
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] res;
        res = 5'd0;
        if (c inside {[8'h30:8'h39]}) begin
            res = {1'b1, 4'(c - 8'h30)};
        end else if (c inside {[8'h61:8'h66]}) begin
            res = {1'b1, 4'(c - 8'h57)};
        end else if (c inside {[8'h41:8'h46]}) begin
            res = {1'b1, 4'(c - 8'h37)};
        end
        return res;
    endfunction

endpackage

>>> design/chunked_body_completion_check.sv
// Chunked body completion check: takes one byte of a chunked transfer-coded
// body per cycle and returns one verdict per byte (incomplete, complete or
// malformed), in the cycle after the transfer. The size line, chunk payload count
// and terminator checks are a single state update per byte, so a byte can be
// taken every cycle; the input stalls only while a finished verdict is held by
// a stalled output. i_body_start clears the parse state ahead of its byte.
// Chunk sizes wider than SIZE_BITS bits are reported as malformed.
module chunked_body_completion_check #(
    parameter int SIZE_BITS = cbcc_pkg::SIZE_BITS_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_body_start,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_verdict
);

    cbcc_pkg::t_phase   r_phase, n_phase, w_phase;
    logic [SIZE_BITS-1:0] r_count, n_count, w_count, w_dec;
    logic               r_digit, n_digit, w_digit;
    cbcc_pkg::t_verdict r_verdict, n_verdict;
    logic               r_out_valid;
    logic [4:0]         w_hex;
    logic               w_accept;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_verdict   = r_verdict;

    // body start clears state ahead of the byte
    assign w_phase = i_body_start ? cbcc_pkg::PH_SIZE : r_phase;
    assign w_count = i_body_start ? '0 : r_count;
    assign w_digit = i_body_start ? 1'b0 : r_digit;
    assign w_hex   = cbcc_pkg::hex_value(i_data_byte);
    assign w_dec   = w_count - SIZE_BITS'(1);

    always_comb begin
        n_phase = w_phase;
        n_count = w_count;
        n_digit = w_digit;
        case (w_phase)
            cbcc_pkg::PH_SIZE: begin
                if (w_hex[4]) begin
                    if (w_count[SIZE_BITS-1 -: 4] != 4'd0) begin
                        n_phase = cbcc_pkg::PH_BAD;
                    end else begin
                        n_count = {w_count[SIZE_BITS-5:0], w_hex[3:0]};
                        n_digit = 1'b1;
                    end
                end else if (i_data_byte == cbcc_pkg::CH_SEMI) begin
                    n_phase = w_digit ? cbcc_pkg::PH_EXT : cbcc_pkg::PH_BAD;
                end else if (i_data_byte == cbcc_pkg::CH_CR) begin
                    n_phase = cbcc_pkg::PH_SIZE_CR;
                end else begin
                    n_phase = cbcc_pkg::PH_BAD;
                end
            end
            cbcc_pkg::PH_SIZE_CR: begin
                if (i_data_byte == cbcc_pkg::CH_LF && w_digit) begin
                    n_phase = (w_count == '0) ? cbcc_pkg::PH_TRAIL : cbcc_pkg::PH_DATA;
                end else begin
                    n_phase = cbcc_pkg::PH_BAD;
                end
            end
            cbcc_pkg::PH_EXT: begin
                if (i_data_byte == cbcc_pkg::CH_CR) begin
                    n_phase = cbcc_pkg::PH_EXT_CR;
                end
            end
            cbcc_pkg::PH_EXT_CR: begin
                if (i_data_byte == cbcc_pkg::CH_LF) begin
                    n_phase = (w_count == '0) ? cbcc_pkg::PH_TRAIL : cbcc_pkg::PH_DATA;
                end else if (i_data_byte != cbcc_pkg::CH_CR) begin
                    n_phase = cbcc_pkg::PH_EXT;
                end
            end
            cbcc_pkg::PH_DATA: begin
                n_count = w_dec;
                if (w_dec == '0) begin
                    n_phase = cbcc_pkg::PH_DATA_CR;
                end
            end
            cbcc_pkg::PH_DATA_CR: begin
                n_phase = (i_data_byte == cbcc_pkg::CH_CR) ? cbcc_pkg::PH_DATA_LF
                                                           : cbcc_pkg::PH_BAD;
            end
            cbcc_pkg::PH_DATA_LF: begin
                if (i_data_byte == cbcc_pkg::CH_LF) begin
                    n_phase = cbcc_pkg::PH_SIZE;
                    n_count = '0;
                    n_digit = 1'b0;
                end else begin
                    n_phase = cbcc_pkg::PH_BAD;
                end
            end
            cbcc_pkg::PH_TRAIL: begin
                if (i_data_byte == cbcc_pkg::CH_CR) begin
                    n_phase = cbcc_pkg::PH_TRAIL_CR;
                end
            end
            cbcc_pkg::PH_TRAIL_CR: begin
                if (i_data_byte == cbcc_pkg::CH_LF) begin
                    n_phase = cbcc_pkg::PH_DONE;
                end else if (i_data_byte != cbcc_pkg::CH_CR) begin
                    n_phase = cbcc_pkg::PH_TRAIL;
                end
            end
            default: begin
                n_phase = w_phase;
            end
        endcase
    end

    always_comb begin
        case (n_phase)
            cbcc_pkg::PH_DONE: n_verdict = cbcc_pkg::VERDICT_COMPLETE;
            cbcc_pkg::PH_BAD:  n_verdict = cbcc_pkg::VERDICT_MALFORMED;
            default:           n_verdict = cbcc_pkg::VERDICT_INCOMPLETE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= cbcc_pkg::PH_SIZE;
            r_count     <= '0;
            r_digit     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_phase     <= n_phase;
                r_count     <= n_count;
                r_digit     <= n_digit;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_verdict <= n_verdict;
        end
    end

    // verdict agrees with the phase left by the last transfer
    a_verdict_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(w_accept) && $past(i_rst_n) |->
            ((r_verdict == cbcc_pkg::VERDICT_COMPLETE) == (r_phase == cbcc_pkg::PH_DONE)) &&
            ((r_verdict == cbcc_pkg::VERDICT_MALFORMED) == (r_phase == cbcc_pkg::PH_BAD)))
        else $error("verdict does not match parse phase");

    // payload phase never holds an empty count
    a_data_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == cbcc_pkg::PH_DATA |-> r_count != '0)
        else $error("payload phase with zero count");

    // extension and payload only follow a size with a digit
    a_digit_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == cbcc_pkg::PH_EXT || r_phase == cbcc_pkg::PH_EXT_CR ||
         r_phase == cbcc_pkg::PH_DATA) |-> r_digit)
        else $error("size line accepted without a digit");

    // complete sticks until a new body starts
    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(r_phase == cbcc_pkg::PH_DONE) && !$past(w_accept && i_body_start)
            |-> r_phase == cbcc_pkg::PH_DONE)
        else $error("complete state left without body start");

    // a held verdict is not overwritten while the output stalls
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |-> !w_accept)
        else $error("transfer taken over a stalled verdict");

endmodule
